// ===== hdl/round_robin_time_slice_scheduler_unit_assert.svh =====
// Assertion macros shared by the scheduler checker.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed: next-cycle property");

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed: same-cycle property");

`endif

// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared field widths, event codes and the ring entry type of the scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int ID_W   = 8;
  localparam int SVC_W  = 16;
  localparam int TIME_W = 32;
  localparam int EV_W   = 3;

  // Event codes reported with every result item.
  localparam logic [EV_W-1:0] EV_ACCEPTED = 3'd0;
  localparam logic [EV_W-1:0] EV_DROPPED  = 3'd1;
  localparam logic [EV_W-1:0] EV_RAN      = 3'd2;
  localparam logic [EV_W-1:0] EV_FINISHED = 3'd3;
  localparam logic [EV_W-1:0] EV_IDLE     = 3'd4;

  // One slot of the ready ring: task id, requested service and ticks run.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] svc;
    logic [SVC_W-1:0] ran;
  } entry_t;

endpackage

// ===== hdl/rrts_ring.sv =====
// ----------------------------------------------------------------------------
// rrts_ring
// Ready-ring storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rrts_ring import rrts_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr1,
  input  logic [$clog2(DEPTH)-1:0] rd_addr2,
  output entry_t                   rd_data1,
  output entry_t                   rd_data2
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write in the same cycle is passed through, so the read registers
  // always mirror the array contents after the current edge.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr1)) begin
      rd_data1 <= wr_data;
    end else begin
      rd_data1 <= mem[rd_addr1];
    end
    if (wr_en && (wr_addr == rd_addr2)) begin
      rd_data2 <= wr_data;
    end else begin
      rd_data2 <= mem[rd_addr2];
    end
  end

endmodule

// ===== hdl/round_robin_time_slice_scheduler_unit.sv =====
// Latency: the result of an item accepted at one edge is shown, with done high, in the next cycle.
// Throughput: one item per clock; busy is never raised outside reset.
// The figure is set by the head update, which works from a head register and two successor
// entries that the ring prefetches through its two registered read ports.
// Reset: rst is synchronous; the ring is empty, time_slice is 1 and the tick count is zero.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler_unit
// Round-robin scheduler with a time quantum over a ring of ready tasks.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_unit import rrts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SVC_W-1:0]  cfg_wdata,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [ID_W-1:0]   task_id,
  input  logic [SVC_W-1:0]  service_time,
  output logic              done,
  output logic [EV_W-1:0]   event_res,
  output logic [ID_W-1:0]   task_out,
  output logic [TIME_W-1:0] time_now
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] DEPTH = SUM_W'(MAX_TASKS);
  localparam logic [CNT_W-1:0] FULL  = CNT_W'(MAX_TASKS);
  localparam logic [SVC_W-1:0] SAT   = {SVC_W{1'b1}};

  // Ring positions are below the depth and an offset adds at most the depth,
  // so one conditional subtract brings a sum back into range.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH) ? (s - DEPTH) : s;
    return r[IDX_W-1:0];
  endfunction

  // Architectural state.
  logic [SVC_W-1:0]  time_slice;
  logic [IDX_W-1:0]  head_ptr, head_ptr_next;
  logic [CNT_W-1:0]  task_count, task_count_next;
  logic [SVC_W-1:0]  slice_used, slice_used_next;
  logic              rotate_pending, rotate_pending_next;
  logic [TIME_W-1:0] elapsed, elapsed_next;

  // The head task is kept in registers; its ran count lives only here until
  // the task is rotated back into the ring.
  entry_t head_ent, head_ent_next;
  entry_t nxt1, nxt2;

  logic [EV_W-1:0] event_next;
  logic [ID_W-1:0] who_next;

  // Ring port signals.
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr1, rd_addr2;

  // Tick datapath.
  logic             accept;
  logic             do_rot;
  logic [IDX_W-1:0] run_ptr;
  entry_t           run_ent, after_ent;
  logic [SVC_W-1:0] ran_inc, need, limit, slice_base, slice_inc;
  logic             finish;

  assign busy     = rst;
  assign accept   = start & ~busy;
  assign time_now = elapsed;

  always_comb begin
    // A pending rotation moves the head to the tail before this tick runs.
    // With a single task the tail slot is the next slot, so the head data
    // stays; with two tasks the entry after the runner is the rotated one.
    do_rot    = rotate_pending && (task_count != '0);
    run_ptr   = do_rot ? wrap_idx(SUM_W'(head_ptr) + SUM_W'(1)) : head_ptr;
    run_ent   = (do_rot && (task_count != CNT_W'(1))) ? nxt1 : head_ent;
    after_ent = do_rot ? ((task_count == CNT_W'(2)) ? head_ent : nxt2) : nxt1;

    ran_inc    = run_ent.ran + SVC_W'(1);
    need       = (run_ent.svc == '0) ? SVC_W'(1) : run_ent.svc;
    limit      = (time_slice == '0) ? SVC_W'(1) : time_slice;
    slice_base = rotate_pending ? '0 : slice_used;
    slice_inc  = (slice_base == SAT) ? SAT : (slice_base + SVC_W'(1));
    finish     = (ran_inc >= need);

    head_ptr_next       = head_ptr;
    task_count_next     = task_count;
    slice_used_next     = slice_used;
    rotate_pending_next = rotate_pending;
    elapsed_next        = elapsed;
    head_ent_next       = head_ent;
    event_next          = EV_IDLE;
    who_next            = '0;

    wr_en   = 1'b0;
    wr_addr = wrap_idx(SUM_W'(head_ptr) + SUM_W'(task_count));
    wr_data = head_ent;

    if (accept) begin
      if (!req_type) begin
        who_next = task_id;
        if (task_count == FULL) begin
          event_next = EV_DROPPED;
        end else begin
          wr_en           = 1'b1;
          wr_data.id      = task_id;
          wr_data.svc     = service_time;
          wr_data.ran     = '0;
          task_count_next = task_count + CNT_W'(1);
          if (task_count == '0) begin
            head_ent_next = wr_data;
          end
          event_next = EV_ACCEPTED;
        end
      end else begin
        elapsed_next = elapsed + TIME_W'(1);
        if (rotate_pending) begin
          rotate_pending_next = 1'b0;
          slice_used_next     = '0;
          if (task_count != '0) begin
            wr_en         = 1'b1;
            head_ptr_next = run_ptr;
          end
        end
        if (task_count == '0) begin
          event_next = EV_IDLE;
          who_next   = '0;
        end else begin
          who_next = run_ent.id;
          if (finish) begin
            head_ptr_next   = wrap_idx(SUM_W'(run_ptr) + SUM_W'(1));
            task_count_next = task_count - CNT_W'(1);
            slice_used_next = '0;
            head_ent_next   = after_ent;
            event_next      = EV_FINISHED;
          end else begin
            head_ent_next     = run_ent;
            head_ent_next.ran = ran_inc;
            slice_used_next   = slice_inc;
            if (slice_inc >= limit) begin
              rotate_pending_next = 1'b1;
            end
            event_next = EV_RAN;
          end
        end
      end
    end

    // Prefetch the two slots behind the coming head.
    rd_addr1 = wrap_idx(SUM_W'(head_ptr_next) + SUM_W'(1));
    rd_addr2 = wrap_idx(SUM_W'(head_ptr_next) + SUM_W'(2));
  end

  rrts_ring #(
    .DEPTH (MAX_TASKS)
  ) u_ring (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr1 (rd_addr1),
    .rd_addr2 (rd_addr2),
    .rd_data1 (nxt1),
    .rd_data2 (nxt2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice     <= SVC_W'(1);
      head_ptr       <= '0;
      task_count     <= '0;
      slice_used     <= '0;
      rotate_pending <= 1'b0;
      elapsed        <= '0;
      done           <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_slice <= cfg_wdata;
      end
      head_ptr       <= head_ptr_next;
      task_count     <= task_count_next;
      slice_used     <= slice_used_next;
      rotate_pending <= rotate_pending_next;
      elapsed        <= elapsed_next;
      done           <= accept;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    head_ent <= head_ent_next;
    if (accept) begin
      event_res <= event_next;
      task_out  <= who_next;
    end
  end

endmodule

// ===== hdl/rrts_checker.sv =====
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "round_robin_time_slice_scheduler_unit_assert.svh"

module rrts_checker import rrts_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              req_type,
  input logic [ID_W-1:0]   task_id,
  input logic              done,
  input logic [EV_W-1:0]   event_res,
  input logic [ID_W-1:0]   task_out,
  input logic [TIME_W-1:0] time_now
);

  `RRTS_ASSERT_NEXT(a_one_result_per_item, start && !busy, done)
  `RRTS_ASSERT_NEXT(a_tick_advances_time, start && !busy && req_type, time_now == $past(time_now) + 32'd1)
  `RRTS_ASSERT_NEXT(a_arrival_keeps_time, start && !busy && !req_type, time_now == $past(time_now))
  `RRTS_ASSERT_NEXT(a_arrival_echo, start && !busy && !req_type, (task_out == $past(task_id)) && ((event_res == EV_ACCEPTED) || (event_res == EV_DROPPED)))
  `RRTS_ASSERT_SAME(a_idle_no_task, done && (event_res == EV_IDLE), task_out == '0)

endmodule

bind round_robin_time_slice_scheduler_unit rrts_checker u_rrts_checker (.*);
